// ===== sv/tcr_pkg.sv =====
// Shared types and constants for the trace column rasteriser.
`default_nettype none

package tcr_pkg;

  // Configuration register indexes
  localparam logic CFG_FIRST_COLUMN = 1'b0;
  localparam logic CFG_LINE_COLOUR  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] FIRST_COLUMN_RST = 8'd4;
  localparam logic [7:0] LINE_COLOUR_RST  = 8'd0;

  // Column counter saturates here
  localparam logic [8:0] COL_CNT_MAX = 9'd511;

  typedef struct packed {
    logic               start_of_trace;
    logic               sample_valid;
    logic signed [15:0] sample_row;
  } in_req_t;

  typedef struct packed {
    logic [7:0] pixel_column;
    logic [5:0] pixel_row;
    logic [7:0] pixel_colour;
    logic       last_write;
  } out_req_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic setup;
    logic push_sample;
    logic push_fill;
  } tcr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sample_wr;
    logic fill_en;
    logic fill_last;
    logic out_free;
  } tcr_sts_t;

endpackage

`default_nettype wire

// ===== sv/tcr_ctrl.sv =====
// Controller: sequences accept, span setup, sample write and gap fill.
`default_nettype none

module tcr_ctrl
  import tcr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire tcr_sts_t sts_i,
  output tcr_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_SAMPLE,
    S_FILL
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  assign in_ready_o = in_ready_q;

  // Commands follow the state and the output register's room
  always_comb begin
    cmd_o.accept      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.setup       = (state_q == S_SETUP);
    cmd_o.push_sample = (state_q == S_SAMPLE) && sts_i.sample_wr && sts_i.out_free;
    cmd_o.push_fill   = (state_q == S_FILL) && sts_i.out_free;
  end

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_SETUP;
            in_ready_q <= 1'b0;
          end
        end
        S_SETUP: begin
          state_q <= S_SAMPLE;
        end
        S_SAMPLE: begin
          if (!sts_i.sample_wr || sts_i.out_free) begin
            if (sts_i.fill_en) begin
              state_q <= S_FILL;
            end else begin
              state_q    <= S_IDLE;
              in_ready_q <= 1'b1;
            end
          end
        end
        S_FILL: begin
          if (sts_i.out_free && sts_i.fill_last) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/tcr_datapath.sv =====
// Datapath: trace state, span clamp and split, row walker, output register.
`default_nettype none

module tcr_datapath
  import tcr_pkg::*;
#(
  parameter int PLOT_WIDTH  = 256,
  parameter int PLOT_HEIGHT = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire in_req_t  in_data_i,
  input  wire tcr_cmd_t cmd_i,
  output tcr_sts_t      sts_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_req_t      out_data_o
);

  localparam logic [8:0]         PlotWidthC = 9'(PLOT_WIDTH);
  localparam logic [5:0]         RowMaxC    = 6'(PLOT_HEIGHT - 1);
  localparam logic signed [15:0] RowMaxS    = 16'(PLOT_HEIGHT - 1);
  localparam logic [16:0]        HeightC    = 17'(PLOT_HEIGHT);

  // Configuration
  logic [7:0] first_column_q, line_colour_q;

  // Trace state
  logic [8:0]         col_cnt_q;
  logic signed [15:0] prev_row_q;
  logic               prev_valid_q, at_first_q;

  // Current request
  logic signed [15:0] row_q, base_row_q;
  logic [8:0]         col_q;
  logic               fill_chk_q, sample_wr_q;

  // Fill walk
  logic       fill_en_q, desc_q;
  logic [5:0] mid_q, y_q, end_q;

  // Output register
  logic     out_valid_q;
  out_req_t out_data_q;

  // Accept side: column of this request
  logic [8:0] col_d;
  logic       first_d;
  always_comb begin
    col_d   = in_data_i.start_of_trace ? {1'b0, first_column_q} : col_cnt_q;
    first_d = in_data_i.start_of_trace | at_first_q;
  end

  // Span setup: gap size, clamp to plot, midpoint, walk bounds
  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic               gap_ok, desc_d, prev_ok, cur_ok, part_ok, span_ok;
  logic [5:0]         a_cl, b_cl, lo, hi, mid_d, start_d, end_full, end_part;
  logic [6:0]         sum, span;

  function automatic logic [5:0] clamp_row(input logic signed [15:0] r);
    logic [5:0] res;
    if (r < 16'sd0) begin
      res = 6'd0;
    end else if (r > RowMaxS) begin
      res = RowMaxC;
    end else begin
      res = r[5:0];
    end
    return res;
  endfunction

  always_comb begin
    diff     = {row_q[15], row_q} - {base_row_q[15], base_row_q};
    desc_d   = diff[16];
    mag      = desc_d ? 17'(-diff) : 17'(diff);
    gap_ok   = (mag > 17'd1) && (mag <= HeightC);
    a_cl     = clamp_row(base_row_q);
    b_cl     = clamp_row(row_q);
    lo       = desc_d ? b_cl : a_cl;
    hi       = desc_d ? a_cl : b_cl;
    span     = {1'b0, hi} - {1'b0, lo};
    // A rising span of one still writes its lower row in the current column
    span_ok  = desc_d ? (span >= 7'd2) : (span != 7'd0);
    sum      = {1'b0, hi} + {1'b0, lo};
    mid_d    = sum[6:1];
    prev_ok  = ((col_q - 9'd1) < PlotWidthC);
    cur_ok   = (col_q < PlotWidthC);
    start_d  = desc_d ? (hi - 6'd1) : ((span == 7'd1) ? lo : (lo + 6'd1));
    end_full = desc_d ? (lo + 6'd1) : (hi - 6'd1);
    end_part = desc_d ? (mid_d + 6'd1) : (mid_d - 6'd1);
    part_ok  = desc_d ? ({1'b0, hi} >= ({1'b0, mid_d} + 7'd2))
                      : (({1'b0, lo} + 7'd2) <= {1'b0, mid_d});
  end

  // Fill pixel column: previous column on the previous sample's side
  logic       use_prev;
  logic [8:0] fill_col;
  always_comb begin
    use_prev = desc_q ? (y_q > mid_q) : (y_q < mid_q);
    fill_col = use_prev ? (col_q - 9'd1) : col_q;
  end

  assign sts_o.sample_wr = sample_wr_q;
  assign sts_o.fill_en   = fill_en_q;
  assign sts_o.fill_last = (y_q == end_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_column_q <= FIRST_COLUMN_RST;
      line_colour_q  <= LINE_COLOUR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FIRST_COLUMN: first_column_q <= cfg_data_i;
        CFG_LINE_COLOUR:  line_colour_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Trace state, updated as each request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q    <= {1'b0, FIRST_COLUMN_RST};
      prev_row_q   <= '0;
      prev_valid_q <= 1'b0;
      at_first_q   <= 1'b1;
    end else if (cmd_i.accept) begin
      col_cnt_q    <= (col_d < COL_CNT_MAX) ? col_d + 9'd1 : COL_CNT_MAX;
      prev_row_q   <= in_data_i.sample_row;
      prev_valid_q <= in_data_i.sample_valid;
      at_first_q   <= 1'b0;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_q       <= in_data_i.sample_row;
      base_row_q  <= prev_row_q;
      col_q       <= col_d;
      fill_chk_q  <= in_data_i.sample_valid && !first_d && prev_valid_q && (col_d != 9'd0);
      sample_wr_q <= in_data_i.sample_valid && !in_data_i.sample_row[15]
                     && ($signed(in_data_i.sample_row) <= RowMaxS)
                     && (col_d < PlotWidthC);
    end
  end

  // Walk setup and row stepping
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      fill_en_q <= fill_chk_q && gap_ok && prev_ok && span_ok && (cur_ok || part_ok);
      desc_q    <= desc_d;
      mid_q     <= mid_d;
      y_q       <= start_d;
      end_q     <= cur_ok ? end_full : end_part;
    end else if (cmd_i.push_fill) begin
      y_q <= desc_q ? (y_q - 6'd1) : (y_q + 6'd1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_sample || cmd_i.push_fill) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_sample) begin
      out_data_q.pixel_column <= col_q[7:0];
      out_data_q.pixel_row    <= row_q[5:0];
      out_data_q.pixel_colour <= line_colour_q;
      out_data_q.last_write   <= !fill_en_q;
    end else if (cmd_i.push_fill) begin
      out_data_q.pixel_column <= fill_col[7:0];
      out_data_q.pixel_row    <= y_q;
      out_data_q.pixel_colour <= line_colour_q;
      out_data_q.last_write   <= sts_o.fill_last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/trace_column_rasterizer_unit.sv =====
// Top level of the trace column rasteriser: controller plus datapath.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one sample request
// per plot column; output channel (out_valid_o/out_ready_i/out_data_o)
// gives framebuffer pixel writes, last_write set on the final write of a
// request. A request with no writes produces nothing on the output.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
// (0 first column, 1 line colour); write only while idle.
// Sequence: a request is taken, passes the setup state, and its first write
// is loaded into the output register from the sample state, or from the
// fill state when only the fill writes. Writes then leave one per cycle from
// the single output register while the receiver is ready, and no new request
// is taken until the last write of the current one is loaded; in_ready_o is
// high only between requests.
// Reset clears the trace: next column is the reset first column (4), no
// previous sample, and the registers return to their reset values.
// When the receiver stalls, the output register holds its write and the
// row walker waits; nothing is lost or repeated.
`default_nettype none

module trace_column_rasterizer_unit
  import tcr_pkg::*;
#(
  parameter int PLOT_WIDTH  = 256,
  parameter int PLOT_HEIGHT = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire in_req_t    in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_req_t        out_data_o
);

  tcr_cmd_t cmd;
  tcr_sts_t sts;

  tcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcr_datapath #(
    .PLOT_WIDTH  (PLOT_WIDTH),
    .PLOT_HEIGHT (PLOT_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Controller issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.setup, cmd.push_sample, cmd.push_fill}))
    else $error("more than one controller command at once");

  // A write is only loaded when the output register has room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.push_sample || cmd.push_fill) |-> (!out_valid_o || out_ready_i))
    else $error("write loaded over a pending write");

  // Taking a request closes the input until it is finished
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input stayed open after a request was taken");

  // Every write lands inside the plot height
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pixel_row <= 6'(PLOT_HEIGHT - 1)))
    else $error("pixel row outside the plot");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the trace column rasteriser: predicts every pixel write and checks it.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcr_pkg::*;

  localparam int PLOT_WIDTH     = 256;
  localparam int PLOT_HEIGHT    = 64;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_WRITES     = 64;
  // Longest a request can keep the block busy, plus margin
  localparam int DRAIN_CYCLES   = PLOT_HEIGHT + 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  // Predicts the pixel writes of each request and holds them until they come out
  class pixel_scoreboard;
    out_req_t   pending_writes[$];
    out_req_t   request_writes[$];
    int         mismatches;
    logic [7:0] first_col;
    logic [7:0] colour;
    int         next_col;
    int         last_row;
    bit         last_valid;
    bit         trace_head;

    function new();
      mismatches = 0;
      first_col  = FIRST_COLUMN_RST;
      colour     = LINE_COLOUR_RST;
      next_col   = int'(FIRST_COLUMN_RST);
      last_row   = 0;
      last_valid = 1'b0;
      trace_head = 1'b1;
    endfunction

    function void write_reg(logic idx, logic [7:0] value);
      case (idx)
        CFG_FIRST_COLUMN: first_col = value;
        CFG_LINE_COLOUR:  colour    = value;
        default: ;
      endcase
    endfunction

    // Writes off screen, past the plot or beyond the per-request cap are dropped
    function void put_pixel(int col, int row);
      out_req_t px;
      if (row < 0 || row >= PLOT_HEIGHT || col >= PLOT_WIDTH) return;
      if (request_writes.size() >= MAX_WRITES) return;
      px.pixel_column = 8'(col);
      px.pixel_row    = 6'(row);
      px.pixel_colour = colour;
      px.last_write   = 1'b0;
      request_writes.push_back(px);
    endfunction

    // Vertical fill between two neighbouring samples, split at the midpoint
    function void fill_span(int prev_col, int from_row, int to_row);
      int mid;
      int y;
      if (from_row > to_row) begin
        if (from_row - to_row > PLOT_HEIGHT) return;  // asymptote
        if (from_row > PLOT_HEIGHT - 1) from_row = PLOT_HEIGHT - 1;
        if (to_row < 0) to_row = 0;
        if (from_row <= to_row) return;
        mid = (from_row + to_row) / 2;
        for (y = from_row - 1; y > mid; y--) put_pixel(prev_col, y);
        for (y = mid; y > to_row; y--) put_pixel(prev_col + 1, y);
      end else begin
        if (to_row - from_row > PLOT_HEIGHT) return;  // asymptote
        if (from_row < 0) from_row = 0;
        if (to_row > PLOT_HEIGHT - 1) to_row = PLOT_HEIGHT - 1;
        if (from_row >= to_row) return;
        mid = (from_row + to_row) / 2;
        for (y = from_row + 1; y < mid; y++) put_pixel(prev_col, y);
        for (y = mid; y < to_row; y++) put_pixel(prev_col + 1, y);
      end
    endfunction

    // Called once per accepted sample request
    function void note_request(in_req_t req);
      int  row;
      int  col;
      int  delta;
      bit  first;
      row = {{16{req.sample_row[15]}}, req.sample_row};
      request_writes.delete();
      if (req.start_of_trace) begin
        col   = int'(first_col);
        first = 1'b1;
      end else begin
        col   = next_col;
        first = trace_head;
      end
      if (req.sample_valid) begin
        put_pixel(col, row);
        if (!first && last_valid && col > 0) begin
          delta = row - last_row;
          if (delta > 1 || delta < -1) fill_span(col - 1, last_row, row);
        end
      end
      last_row   = row;
      last_valid = req.sample_valid;
      trace_head = 1'b0;
      next_col   = (col < int'(COL_CNT_MAX)) ? col + 1 : int'(COL_CNT_MAX);
      if (request_writes.size() > 0) request_writes[$].last_write = 1'b1;
      foreach (request_writes[i]) pending_writes.push_back(request_writes[i]);
    endfunction

    // Called once per accepted pixel write
    function void check_write(out_req_t got);
      out_req_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel write col %0d row %0d colour %0d last %0b",
                   $time, got.pixel_column, got.pixel_row, got.pixel_colour, got.last_write);
        return;
      end
      want = pending_writes.pop_front();
      if (got.pixel_column !== want.pixel_column || got.pixel_row !== want.pixel_row ||
          got.pixel_colour !== want.pixel_colour || got.last_write !== want.last_write) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: pixel write wrong: want col %0d row %0d colour %0d last %0b, got col %0d row %0d colour %0d last %0b",
                   $time, want.pixel_column, want.pixel_row, want.pixel_colour,
                   want.last_write, got.pixel_column, got.pixel_row, got.pixel_colour,
                   got.last_write);
      end
    endfunction

    function void flush_leftover();
      if (pending_writes.size() != 0) begin
        $display("%0d pixel writes never arrived", pending_writes.size());
        mismatches += pending_writes.size();
        pending_writes.delete();
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = CFG_FIRST_COLUMN;
  logic [7:0] cfg_data_i  = 8'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_req_t    in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_req_t   out_data_o;

  pixel_scoreboard scoreboard = new();

  bit hold_output = 1'b0;
  int send_burst  = 0;
  int recv_burst  = 0;
  int stall_cycles = 0;

  trace_column_rasterizer_unit #(
    .PLOT_WIDTH (PLOT_WIDTH),
    .PLOT_HEIGHT(PLOT_HEIGHT)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Idle cycles before the next request; now and then a run with none at all
  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic in_req_t make_sample(bit start, bit valid, int row);
    in_req_t req;
    req.start_of_trace = start;
    req.sample_valid   = valid;
    req.sample_row     = row[15:0];
    return req;
  endfunction

  task automatic send_sample(input in_req_t req);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (!in_ready_o);
    scoreboard.note_request(req);
  endtask

  // Wait for every predicted write, then let a request with no writes finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (scoreboard.pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    scoreboard.write_reg(idx, value);
  endtask

  // Corner cases at the reset configuration
  task automatic run_directed();
    send_sample(make_sample(0, 1, 10));      // first after reset, no fill
    send_sample(make_sample(0, 1, 40));      // rising fill
    send_sample(make_sample(0, 1, 5));       // falling fill
    send_sample(make_sample(0, 1, 6));       // step of one, no fill
    send_sample(make_sample(0, 0, 20));      // NaN
    send_sample(make_sample(0, 1, 50));      // after NaN, no fill
    send_sample(make_sample(0, 1, -32768));  // off screen, asymptote
    send_sample(make_sample(0, 1, -10));
    send_sample(make_sample(0, 1, 30));      // fill clamped at the top row
    send_sample(make_sample(0, 1, 32767));
    send_sample(make_sample(0, 1, 100));
    send_sample(make_sample(0, 1, 63));      // span clamps to nothing
    send_sample(make_sample(0, 1, 0));       // full falling fill
    send_sample(make_sample(0, 1, 64));      // gap of exactly the height
    send_sample(make_sample(0, 1, -1));      // one past the height: skipped
    send_sample(make_sample(0, 1, 1));       // short rise repeats row 0
    send_sample(make_sample(1, 1, 20));      // new trace
    send_sample(make_sample(0, 1, 22));
    send_sample(make_sample(0, 1, 25));      // short rise filled only in the current column
    send_sample(make_sample(1, 0, -1));      // trace starting with NaN
    send_sample(make_sample(0, 1, 5));
    send_sample(make_sample(0, 1, 63));
  endtask

  // Traces of random length; rows mostly walk, with jumps and noise
  task automatic run_random(input int count);
    in_req_t req;
    int      sent;
    int      trace_len;
    int      k;
    int      row;
    sent = 0;
    row  = 32;
    while (sent < count) begin
      trace_len = $urandom_range(1, 40);
      for (k = 0; k < trace_len && sent < count; k++) begin
        req.start_of_trace = (k == 0) ? ($urandom_range(0, 7) != 0)
                                      : ($urandom_range(0, 49) == 0);
        req.sample_valid   = ($urandom_range(0, 11) != 0);
        case ($urandom_range(0, 9))
          0:       row = $signed(16'($urandom));
          1:       row = row + int'($urandom_range(0, 2)) - 1;
          2, 3:    row = int'($urandom_range(0, 63));
          4:       row = int'($urandom_range(0, 90)) - 13;
          default: row = row + int'($urandom_range(0, 30)) - 15;
        endcase
        req.sample_row = row[15:0];
        row = {{16{req.sample_row[15]}}, req.sample_row};
        send_sample(req);
        sent++;
      end
    end
  endtask

  // Result side: random ready gaps, one long hold-off on request
  initial begin : result_sink
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(recv_burst);
      if (hold_output) begin
        gap = HOLD_CYCLES;
        hold_output = 1'b0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      scoreboard.check_write(out_data_o);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    wait_idle();

    // Extremes of both registers; receiver holds off early in this phase
    write_reg(CFG_FIRST_COLUMN, 8'd0);
    write_reg(CFG_LINE_COLOUR, 8'hFF);
    hold_output = 1'b1;
    run_random(52);
    wait_idle();

    write_reg(CFG_FIRST_COLUMN, 8'($urandom_range(0, 255)));
    write_reg(CFG_LINE_COLOUR, 8'($urandom_range(0, 255)));
    run_random(52);
    wait_idle();

    write_reg(CFG_LINE_COLOUR, 8'd0);
    write_reg(CFG_FIRST_COLUMN, 8'($urandom_range(0, 215)));
    run_random(52);
    wait_idle();

    write_reg(CFG_FIRST_COLUMN, 8'($urandom_range(0, 255)));
    write_reg(CFG_LINE_COLOUR, 8'($urandom_range(0, 255)));
    run_random(52);
    wait_idle();

    // Traces from the last column run past the plot edge
    write_reg(CFG_FIRST_COLUMN, 8'd255);
    write_reg(CFG_LINE_COLOUR, 8'($urandom_range(0, 255)));
    run_random(52);
    wait_idle();

    scoreboard.flush_leftover();
    if (scoreboard.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
